// ----- rtl/core/bppm_pkg.sv -----
// Package for the biphasic peak-to-peak meter.
// Holds the register index codes, the scale reset value and the configuration struct.
// No dependencies.
`default_nettype none

package bppm_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int FIELD_BITS      = 16;
	localparam int SCALE_BITS      = 24;
	localparam int CFG_DATA_BITS   = 24;
	localparam int CFG_IDX_BITS    = 2;
	localparam int MV_BITS         = 32;
	localparam int MV_SHIFT        = 9;

	localparam logic [SCALE_BITS-1:0] SCALE_RESET = 24'h01_0000;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_PERIOD = 2'd0,
		CFG_WIDTH  = 2'd1,
		CFG_SCALE  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] period;
		logic [FIELD_BITS-1:0] width;
		logic [SCALE_BITS-1:0] scale;
	} cfg_t;

endpackage

`default_nettype wire

// ----- rtl/core/bppm_cfg.sv -----
// Configuration register bank of the biphasic peak-to-peak meter.
// Depends on bppm_pkg.
`default_nettype none

module bppm_cfg (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [bppm_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  wire logic [bppm_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	output bppm_pkg::cfg_t                            cfg
);

	bppm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period <= '0;
			cfg_q.width  <= '0;
			cfg_q.scale  <= bppm_pkg::SCALE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				bppm_pkg::CFG_PERIOD: cfg_q.period <= cfg_data[bppm_pkg::FIELD_BITS-1:0];
				bppm_pkg::CFG_WIDTH:  cfg_q.width  <= cfg_data[bppm_pkg::FIELD_BITS-1:0];
				bppm_pkg::CFG_SCALE:  cfg_q.scale  <= cfg_data[bppm_pkg::SCALE_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/core/bppm_track.sv -----
// Window tracker: sample position counter, per-window max/min and swing capture.
// Depends on bppm_pkg.
`default_nettype none

module bppm_track #(
	parameter int SAMPLE_BITS = bppm_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire bppm_pkg::cfg_t                    cfg,
	input  wire logic                              acc,
	input  wire logic [bppm_pkg::FIELD_BITS-1:0]   sample,
	input  wire logic                              last_sample,
	input  wire logic                              adv,
	output logic                                   valid_s1,
	output logic [SAMPLE_BITS-1:0]                 pp0_s1,
	output logic [SAMPLE_BITS-1:0]                 pp1_s1
);

	localparam int PB = bppm_pkg::FIELD_BITS + 2;

	logic [bppm_pkg::FIELD_BITS-1:0] idx_q;
	logic [SAMPLE_BITS-1:0]          max0_q, min0_q, max1_q, min1_q;
	logic [SAMPLE_BITS-1:0]          nmax0, nmin0, nmax1, nmin1, smp;
	logic [bppm_pkg::FIELD_BITS-2:0] half;
	logic [bppm_pkg::FIELD_BITS-3:0] len;
	logic [bppm_pkg::FIELD_BITS-2:0] start0;
	logic [PB-1:0]                   pos, end0, start1, end1;
	logic                            in0, in1;

	always_comb begin
		half   = cfg.period[bppm_pkg::FIELD_BITS-1:1];
		len    = half[bppm_pkg::FIELD_BITS-2:1];
		start0 = cfg.width[bppm_pkg::FIELD_BITS-1:1];
		pos    = PB'(idx_q);
		end0   = PB'(start0) + PB'(len);
		start1 = PB'(start0) + PB'(half);
		end1   = start1 + PB'(len);
		in0    = (pos >= PB'(start0)) && (pos < end0);
		in1    = (pos >= start1) && (pos < end1);
		smp    = sample[SAMPLE_BITS-1:0];
		nmax0  = (in0 && smp > max0_q) ? smp : max0_q;
		nmin0  = (in0 && smp < min0_q) ? smp : min0_q;
		nmax1  = (in1 && smp > max1_q) ? smp : max1_q;
		nmin1  = (in1 && smp < min1_q) ? smp : min1_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			max0_q   <= '0;
			min0_q   <= '1;
			max1_q   <= '0;
			min1_q   <= '1;
			valid_s1 <= 1'b0;
		end else begin
			if (acc) begin
				if (last_sample) begin
					idx_q  <= '0;
					max0_q <= '0;
					min0_q <= '1;
					max1_q <= '0;
					min1_q <= '1;
				end else begin
					if (idx_q != '1)
						idx_q <= idx_q + 1'b1;
					max0_q <= nmax0;
					min0_q <= nmin0;
					max1_q <= nmax1;
					min1_q <= nmin1;
				end
			end
			if (acc && last_sample)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
		end
	end

	// empty window leaves max below min: swing is zero
	always_ff @(posedge clk) begin
		if (acc && last_sample) begin
			pp0_s1 <= (nmax0 >= nmin0) ? nmax0 - nmin0 : '0;
			pp1_s1 <= (nmax1 >= nmin1) ? nmax1 - nmin1 : '0;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/bppm_scale.sv -----
// Scaling stage and output register: ((pp0 + pp1) * scale) >> 9.
// Depends on bppm_pkg.
`default_nettype none

module bppm_scale #(
	parameter int SAMPLE_BITS = bppm_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [bppm_pkg::SCALE_BITS-1:0]   scale,
	input  wire logic                              valid_s1,
	input  wire logic [SAMPLE_BITS-1:0]            pp0_s1,
	input  wire logic [SAMPLE_BITS-1:0]            pp1_s1,
	input  wire logic                              out_stall,
	output logic                                   adv,
	output logic                                   out_valid,
	output logic [bppm_pkg::MV_BITS-1:0]           load_mv_q8,
	output logic [bppm_pkg::FIELD_BITS-1:0]        swing_first,
	output logic [bppm_pkg::FIELD_BITS-1:0]        swing_second
);

	localparam int SB = SAMPLE_BITS + 1;
	localparam int PW = SB + bppm_pkg::SCALE_BITS;

	logic                           valid_s2;
	logic [SB-1:0]                  sum;
	logic [PW-1:0]                  prod;
	logic [bppm_pkg::MV_BITS-1:0]   mv_s2;
	logic [SAMPLE_BITS-1:0]         pp0_s2, pp1_s2;

	// product stays below 2^41, so the shifted value always fits 32 bits
	always_comb begin
		sum  = SB'(pp0_s1) + SB'(pp1_s1);
		prod = PW'(sum) * PW'(scale);
		adv  = !valid_s2 || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			mv_s2  <= bppm_pkg::MV_BITS'(prod >> bppm_pkg::MV_SHIFT);
			pp0_s2 <= pp0_s1;
			pp1_s2 <= pp1_s1;
		end
	end

	assign out_valid    = valid_s2;
	assign load_mv_q8   = mv_s2;
	assign swing_first  = bppm_pkg::FIELD_BITS'(pp0_s2);
	assign swing_second = bppm_pkg::FIELD_BITS'(pp1_s2);

endmodule

`default_nettype wire

// ----- rtl/core/biphasic_peak_to_peak_meter.sv -----
// Biphasic peak-to-peak meter, top level.
// Instantiates bppm_cfg, bppm_track and bppm_scale; depends on bppm_pkg.
//
// Accepts one sample per clock while in_stall is low. Every sample updates the running max/min
// of the two quarter-period windows, which start half a period apart; a sample marked last
// freezes both swings into the swing register, and the scaled result is registered in the
// output register, from which it appears on the output. The input stalls only while both the
// swing register and the output register hold results that the receiver has not taken.
`default_nettype none

module biphasic_peak_to_peak_meter #(
	parameter int SAMPLE_BITS = bppm_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [bppm_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  wire logic [bppm_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [bppm_pkg::FIELD_BITS-1:0]      sample,
	input  wire logic                                 last_sample,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic [bppm_pkg::MV_BITS-1:0]              load_mv_q8,
	output logic [bppm_pkg::FIELD_BITS-1:0]           swing_first,
	output logic [bppm_pkg::FIELD_BITS-1:0]           swing_second
);

	bppm_pkg::cfg_t          cfg;
	logic                    acc, adv, valid_s1;
	logic [SAMPLE_BITS-1:0]  pp0_s1, pp1_s1;

	assign in_stall = valid_s1 && !adv;
	assign acc      = in_valid && !in_stall;

	bppm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bppm_track #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.acc         (acc),
		.sample      (sample),
		.last_sample (last_sample),
		.adv         (adv),
		.valid_s1    (valid_s1),
		.pp0_s1      (pp0_s1),
		.pp1_s1      (pp1_s1)
	);

	bppm_scale #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.scale        (cfg.scale),
		.valid_s1     (valid_s1),
		.pp0_s1       (pp0_s1),
		.pp1_s1       (pp1_s1),
		.out_stall    (out_stall),
		.adv          (adv),
		.out_valid    (out_valid),
		.load_mv_q8   (load_mv_q8),
		.swing_first  (swing_first),
		.swing_second (swing_second)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without output backpressure");

	assert property (@(posedge clk) disable iff (!arst_n)
		(acc && last_sample) |=> valid_s1)
		else $error("last sample transaction did not load the swing register");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s1))
		else $error("result appeared without a pending swing");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((swing_first >> SAMPLE_BITS) == '0 && (swing_second >> SAMPLE_BITS) == '0))
		else $error("swing exceeds sample range");

endmodule

`default_nettype wire

// ----- verif/bppm_reading_checker.sv -----
// Scoreboard for the biphasic peak-to-peak meter: watches the config port and both channels,
// predicts each reading from its own copy of the window state and compares field by field.
// Depends on bppm_pkg.
`timescale 1ns / 1ps

module bppm_reading_checker
	import bppm_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic [FIELD_BITS-1:0]    sample,
	input  logic                     last_sample,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic [MV_BITS-1:0]       load_mv_q8,
	input  logic [FIELD_BITS-1:0]    swing_first,
	input  logic [FIELD_BITS-1:0]    swing_second,
	output int                       mismatches,
	output int                       readings_pending,
	output int                       readings_checked
);

	localparam logic [FIELD_BITS-1:0] SAMPLE_MASK = FIELD_BITS'((32'd1 << SAMPLE_BITS) - 1);

	typedef struct packed {
		logic [MV_BITS-1:0]    load_mv;
		logic [FIELD_BITS-1:0] swing0;
		logic [FIELD_BITS-1:0] swing1;
	} meter_reading_t;

	meter_reading_t        readings_due[$];
	meter_reading_t        due;
	cfg_t                  regs;
	logic [FIELD_BITS-1:0] position;
	logic [FIELD_BITS-1:0] hi0, lo0, hi1, lo1;
	int                    errors;
	int                    checked;

	task automatic open_buffer();
		position = '0;
		hi0 = '0;
		lo0 = '1;
		hi1 = '0;
		lo1 = '1;
	endtask

	task automatic absorb_sample(input logic [FIELD_BITS-1:0] raw, input logic closes);
		int unsigned    half_len;
		int unsigned    span;
		int unsigned    start0;
		int unsigned    start1;
		int unsigned    pos;
		logic [FIELD_BITS-1:0] v;
		logic [63:0]    product;
		logic [63:0]    scaled;
		meter_reading_t r;
		half_len = regs.period >> 1;
		span = half_len >> 1;
		start0 = regs.width >> 1;
		start1 = start0 + half_len;
		pos = position;
		v = raw & SAMPLE_MASK;
		if (pos >= start0 && pos < start0 + span) begin
			if (v > hi0) hi0 = v;
			if (v < lo0) lo0 = v;
		end
		if (pos >= start1 && pos < start1 + span) begin
			if (v > hi1) hi1 = v;
			if (v < lo1) lo1 = v;
		end
		if (position != '1) position = position + 1'b1;
		if (closes) begin
			// an empty window leaves max below min and reads as no swing
			r.swing0 = (hi0 >= lo0) ? hi0 - lo0 : '0;
			r.swing1 = (hi1 >= lo1) ? hi1 - lo1 : '0;
			product = (64'(r.swing0) + 64'(r.swing1)) * 64'(regs.scale);
			scaled = product >> MV_SHIFT;
			r.load_mv = (scaled > 64'hFFFF_FFFF) ? '1 : scaled[MV_BITS-1:0];
			readings_due.push_back(r);
			open_buffer();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			readings_due.delete();
			regs.period = '0;
			regs.width = '0;
			regs.scale = SCALE_RESET;
			open_buffer();
			errors = 0;
			checked = 0;
			mismatches <= 0;
			readings_pending <= 0;
			readings_checked <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (readings_due.size() == 0) begin
					$error("unexpected reading: load_mv_q8 %0d swing_first %0d swing_second %0d",
						load_mv_q8, swing_first, swing_second);
					errors++;
				end else begin
					due = readings_due.pop_front();
					if (load_mv_q8 !== due.load_mv) begin
						$error("load_mv_q8: expected %0d, got %0d", due.load_mv, load_mv_q8);
						errors++;
					end
					if (swing_first !== due.swing0) begin
						$error("swing_first: expected %0d, got %0d", due.swing0, swing_first);
						errors++;
					end
					if (swing_second !== due.swing1) begin
						$error("swing_second: expected %0d, got %0d", due.swing1, swing_second);
						errors++;
					end
					checked++;
				end
			end
			if (in_valid && !in_stall) absorb_sample(sample, last_sample);
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_PERIOD: regs.period = cfg_data[FIELD_BITS-1:0];
					CFG_WIDTH:  regs.width = cfg_data[FIELD_BITS-1:0];
					CFG_SCALE:  regs.scale = cfg_data[SCALE_BITS-1:0];
					default: ;
				endcase
			end
			mismatches <= errors;
			readings_pending <= readings_due.size();
			readings_checked <= checked;
		end
	end

endmodule

// ----- verif/tb.sv -----
// Top of the meter regression: clock, reset, config writes and sample transactions with
// random idling on both sides; verdict taken from bppm_reading_checker.
// Depends on bppm_pkg, biphasic_peak_to_peak_meter and bppm_reading_checker.
`timescale 1ns / 1ps

module tb;
	import bppm_pkg::*;

	localparam int WATCHDOG_CYCLES = 5000;
	localparam int HOLD_CYCLES     = 300;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	cfg_idx_t                 cfg_index = CFG_PERIOD;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [FIELD_BITS-1:0]    sample = '0;
	logic                     last_sample = 1'b0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [MV_BITS-1:0]       load_mv_q8;
	logic [FIELD_BITS-1:0]    swing_first;
	logic [FIELD_BITS-1:0]    swing_second;

	int mismatches;
	int readings_pending;
	int readings_checked;

	int send_pct = 0;
	int recv_pct = 0;
	int hold_go = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int samples_sent = 0;
	int settings_done = 0;
	logic [FIELD_BITS-1:0] cur_period = '0;
	logic [FIELD_BITS-1:0] cur_width = '0;

	logic [FIELD_BITS-1:0] pulse [8] = '{16'd5, 16'd5, 16'h0000, 16'hFFFF,
		16'd9, 16'd9, 16'hFFFF, 16'h0000};

	biphasic_peak_to_peak_meter u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample       (sample),
		.last_sample  (last_sample),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.load_mv_q8   (load_mv_q8),
		.swing_first  (swing_first),
		.swing_second (swing_second)
	);

	bppm_reading_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.sample           (sample),
		.last_sample      (last_sample),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.load_mv_q8       (load_mv_q8),
		.swing_first      (swing_first),
		.swing_second     (swing_second),
		.mismatches       (mismatches),
		.readings_pending (readings_pending),
		.readings_checked (readings_checked)
	);

	always #5 clk = ~clk;

	// receiver: random stall, or a long hold-off when requested
	always @(posedge clk) begin
		if (hold_go != hold_seen) begin
			hold_seen <= hold_go;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_CYCLES) begin
				$display("biphasic_peak_to_peak_meter regression: fail");
				$finish;
			end
		end
	end

	function automatic logic [FIELD_BITS-1:0] rand_sample();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return FIELD_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [FIELD_BITS-1:0] pick_points(input int typical_max);
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return FIELD_BITS'($urandom);
			default: return FIELD_BITS'($urandom_range(typical_max));
		endcase
	endfunction

	function automatic logic [SCALE_BITS-1:0] pick_scale();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return SCALE_RESET;
			3: return SCALE_BITS'($urandom_range(1 << 18));
			default: return SCALE_BITS'($urandom);
		endcase
	endfunction

	task automatic send_sample(input logic [FIELD_BITS-1:0] value, input logic closes);
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= value;
		last_sample <= closes;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		samples_sent++;
	endtask

	task automatic send_buffer(input int len, input logic closes);
		for (int i = 0; i < len; i++)
			send_sample(rand_sample(), closes && (i == len - 1));
	endtask

	// drain: no transaction offered, all readings back, pipeline given time to empty
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (readings_pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_regs(input logic [FIELD_BITS-1:0] period,
		input logic [FIELD_BITS-1:0] width, input logic [SCALE_BITS-1:0] scale);
		cfg_we <= 1'b1;
		cfg_index <= CFG_PERIOD;
		cfg_data <= CFG_DATA_BITS'(period);
		@(posedge clk);
		cfg_index <= CFG_WIDTH;
		cfg_data <= CFG_DATA_BITS'(width);
		@(posedge clk);
		cfg_index <= CFG_SCALE;
		cfg_data <= scale;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_period = period;
		cur_width = width;
		settings_done++;
	endtask

	task automatic random_buffer();
		int reach;
		int len;
		reach = (cur_width >> 1) + (cur_period >> 1) + (cur_period >> 2);
		len = reach + $urandom_range(3);
		if (len < 1) len = 1;
		if (len > 96) len = $urandom_range(1, 96);
		if ($urandom_range(4) == 0) len = $urandom_range(1, len);
		send_buffer(len, $urandom_range(9) != 0);
	endtask

	task automatic random_phase(input int sender_pct, input int receiver_pct, input int quota);
		int phase_start;
		int setting_start;
		phase_start = samples_sent;
		send_pct = sender_pct;
		recv_pct <= receiver_pct;
		while (samples_sent - phase_start < quota) begin
			settle();
			program_regs(pick_points(48), pick_points(24), pick_scale());
			setting_start = samples_sent;
			while (samples_sent - setting_start < 60 && samples_sent - phase_start < quota)
				random_buffer();
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: zero-length windows, both swings empty
		send_sample(16'h1234, 1'b1);
		settle();
		program_regs(16'd8, 16'd4, SCALE_RESET);
		for (int i = 0; i < 8; i++) send_sample(pulse[i], i == 7);
		settle();
		program_regs(16'd8, 16'd4, '1);
		for (int i = 0; i < 8; i++) send_sample(pulse[i], i == 7);
		settle();
		program_regs('1, '1, '0);
		send_buffer(3, 1'b1);
		settle();
		program_regs(16'd6, 16'd1, 24'd12345);
		send_buffer(4, 1'b1);

		random_phase(12, 74, 350);
		random_phase(74, 12, 300);

		// output held off while the sender keeps offering short buffers
		send_pct = 0;
		recv_pct <= 0;
		settle();
		program_regs(16'd8, 16'd0, SCALE_RESET);
		hold_go <= hold_go + 1;
		repeat (40) send_buffer($urandom_range(1, 3), 1'b1);
		random_phase(0, 0, 310);

		in_valid <= 1'b0;
		@(posedge clk);
		while (readings_pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("Covered %0d samples over %0d register settings; %0d readings compared,",
			samples_sent, settings_done, readings_checked);
		$display("including empty windows, windows past the buffer end and an output hold-off.");
		if (mismatches == 0 && readings_pending == 0)
			$display("biphasic_peak_to_peak_meter regression: pass");
		else
			$display("biphasic_peak_to_peak_meter regression: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/bppm_pkg.sv
rtl/core/bppm_cfg.sv
rtl/core/bppm_track.sv
rtl/core/bppm_scale.sv
rtl/core/biphasic_peak_to_peak_meter.sv
verif/bppm_reading_checker.sv
verif/tb.sv
